// ----- rtl/address_range_lookup_table_core_macros.svh -----
// Assertion helpers for the address range lookup table core.
`ifndef ADDRESS_RANGE_LOOKUP_TABLE_CORE_MACROS_SVH
`define ADDRESS_RANGE_LOOKUP_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ARLT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ARLT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/arlt_pkg.sv -----
package arlt_pkg;

  localparam int RANGE_SLOTS_DEF = 64;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] size;
    logic [31:0] module_tag;
    logic [7:0]  section_tag;
  } entry_t;

  typedef struct packed {
    logic        le;
    logic        in_range;
    logic [31:0] offset;
  } cmp_res_t;

endpackage

// ----- rtl/arlt_ram.sv -----
module arlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/arlt_unit.sv -----
module arlt_unit (
  input  logic [31:0]        key,
  input  arlt_pkg::entry_t   entry,
  output arlt_pkg::cmp_res_t res
);

  import arlt_pkg::*;

  logic [31:0] diff;

  assign diff         = key - entry.base;
  assign res.le       = (entry.base <= key);
  assign res.in_range = (entry.base <= key) && (diff < entry.size);
  assign res.offset   = diff;

endmodule

// ----- rtl/arlt_seq.sv -----
module arlt_seq #(
  parameter int RANGE_SLOTS = arlt_pkg::RANGE_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     req_type,
  input  logic [31:0]                    range_base,
  input  logic [31:0]                    range_size,
  input  logic [31:0]                    module_tag,
  input  logic [7:0]                     section_tag,
  input  logic [31:0]                    lookup_addr,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           hit,
  output logic                           rejected,
  output logic [31:0]                    hit_module,
  output logic [7:0]                     hit_section,
  output logic [31:0]                    hit_offset,
  output logic [29:0]                    word_index,
  output logic [31:0]                    key,
  input  arlt_pkg::cmp_res_t             cmp,
  output logic                           ram_we,
  output logic [$clog2(RANGE_SLOTS)-1:0] ram_waddr,
  output arlt_pkg::entry_t               ram_wdata,
  output logic [$clog2(RANGE_SLOTS)-1:0] ram_raddr,
  input  arlt_pkg::entry_t               ram_rdata
);

  import arlt_pkg::*;

  localparam int AW = $clog2(RANGE_SLOTS);
  localparam int CW = $clog2(RANGE_SLOTS + 1);
  localparam logic [CW-1:0] FULL = CW'(RANGE_SLOTS);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_SRCH_RD   = 4'd1;
  localparam logic [3:0] ST_SRCH_CMP  = 4'd2;
  localparam logic [3:0] ST_SHIFT_RD  = 4'd3;
  localparam logic [3:0] ST_SHIFT_WR  = 4'd4;
  localparam logic [3:0] ST_PUT       = 4'd5;
  localparam logic [3:0] ST_FETCH_CMP = 4'd6;
  localparam logic [3:0] ST_DONE      = 4'd7;

  logic [3:0]    state;
  logic [1:0]    req;
  entry_t        new_entry;
  logic [CW-1:0] lo, hi, idx, count;
  logic [CW:0]   mid_sum;
  logic [AW-1:0] mid;
  logic [CW-1:0] idx_dec;
  logic [CW-1:0] lo_dec;
  logic [31:0]   ins_base;
  logic          ins_reject;
  logic          res_hit, res_rej;
  logic [31:0]   res_module, res_offset;
  logic [7:0]    res_section;
  logic          accept;
  logic          out_free;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state != ST_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign ins_base   = {range_base[31:2], 2'b00};
  assign ins_reject = (ins_base == '0) || (count == FULL);
  assign mid_sum    = {1'b0, lo} + {1'b0, hi};
  assign mid        = mid_sum[AW:1];
  assign idx_dec    = idx - CW'(1);
  assign lo_dec     = lo - CW'(1);

  always_comb begin
    case (state)
      ST_SRCH_RD:  ram_raddr = (lo < hi) ? mid : lo_dec[AW-1:0];
      ST_SHIFT_RD: ram_raddr = idx_dec[AW-1:0];
      default:     ram_raddr = mid;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = lo[AW-1:0];
    ram_wdata = new_entry;
    case (state)
      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx[AW-1:0];
        ram_wdata = ram_rdata;
      end
      ST_PUT: begin
        ram_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            req                   <= req_type;
            res_hit               <= 1'b0;
            res_rej               <= (req_type == REQ_INSERT) && ins_reject;
            res_module            <= '0;
            res_section           <= '0;
            res_offset            <= '0;
            lo                    <= '0;
            hi                    <= count;
            new_entry.base        <= ins_base;
            new_entry.size        <= range_size;
            new_entry.module_tag  <= module_tag;
            new_entry.section_tag <= section_tag;
            case (req_type)
              REQ_CLEAR: begin
                count <= '0;
                state <= ST_DONE;
              end
              REQ_INSERT: begin
                key   <= ins_base;
                state <= ins_reject ? ST_DONE : ST_SRCH_RD;
              end
              REQ_LOOKUP: begin
                key   <= lookup_addr;
                state <= ST_SRCH_RD;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_SRCH_RD: begin
          if (lo < hi) begin
            state <= ST_SRCH_CMP;
          end else if (req == REQ_INSERT) begin
            idx   <= count;
            state <= (count > lo) ? ST_SHIFT_RD : ST_PUT;
          end else if (lo == '0) begin
            state <= ST_DONE;
          end else begin
            // read of entry lo-1 issued this cycle
            state <= ST_FETCH_CMP;
          end
        end
        ST_SRCH_CMP: begin
          // equal bases go right, so the newest of a run of equals is found
          if (cmp.le) begin
            lo <= CW'(mid) + CW'(1);
          end else begin
            hi <= CW'(mid);
          end
          state <= ST_SRCH_RD;
        end
        ST_SHIFT_RD: state <= ST_SHIFT_WR;
        ST_SHIFT_WR: begin
          idx   <= idx_dec;
          state <= (idx_dec > lo) ? ST_SHIFT_RD : ST_PUT;
        end
        ST_PUT: begin
          count <= count + CW'(1);
          state <= ST_DONE;
        end
        ST_FETCH_CMP: begin
          if (cmp.in_range) begin
            res_hit     <= 1'b1;
            res_module  <= ram_rdata.module_tag;
            res_section <= ram_rdata.section_tag;
            res_offset  <= cmp.offset;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      hit         <= res_hit;
      rejected    <= res_rej;
      hit_module  <= res_module;
      hit_section <= res_section;
      hit_offset  <= res_offset;
      word_index  <= res_offset[31:2];
    end
  end

endmodule

// ----- rtl/address_range_lookup_table_core.sv -----
// Clear, rejected insert and unused request go straight to the result once accepted.
// Lookup: a read and a compare per search step, at most clog2(count+1) steps, then
// a fetch and compare of entry lo-1 (none when no base fits). Insert: the same search,
// then a read and a write per entry moved up (single RAM port pair) and the put.
// One word in flight; the next is taken the cycle after out_stall lets the result load.
// Reset clears the entry count and handshake state; table contents are not cleared.
`include "address_range_lookup_table_core_macros.svh"

module address_range_lookup_table_core #(
  parameter int RANGE_SLOTS = arlt_pkg::RANGE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] range_base,
  input  logic [31:0] range_size,
  input  logic [31:0] module_tag,
  input  logic [7:0]  section_tag,
  input  logic [31:0] lookup_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic        rejected,
  output logic [31:0] hit_module,
  output logic [7:0]  hit_section,
  output logic [31:0] hit_offset,
  output logic [29:0] word_index
);

  import arlt_pkg::*;

  localparam int AW = $clog2(RANGE_SLOTS);

  logic [31:0]   key;
  cmp_res_t      cmp;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;
  logic          fields_zero;

  arlt_seq #(.RANGE_SLOTS(RANGE_SLOTS)) u_seq (
    .clk, .rst,
    .in_valid, .in_stall,
    .req_type, .range_base, .range_size, .module_tag, .section_tag, .lookup_addr,
    .out_valid, .out_stall,
    .hit, .rejected, .hit_module, .hit_section, .hit_offset, .word_index,
    .key, .cmp,
    .ram_we, .ram_waddr, .ram_wdata, .ram_raddr, .ram_rdata
  );

  arlt_unit u_unit (
    .key   (key),
    .entry (ram_rdata),
    .res   (cmp)
  );

  arlt_ram #(.WIDTH($bits(entry_t)), .DEPTH(RANGE_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign fields_zero = (hit_offset == '0) && (hit_module == '0) && (hit_section == '0);

  `ARLT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")
  `ARLT_ASSERT_NOW(a_hit_not_rejected, out_valid, !(hit && rejected), "hit and rejected together")
  `ARLT_ASSERT_NOW(a_miss_zero, out_valid && !hit, fields_zero, "miss fields not zero")
  `ARLT_ASSERT_NOW(a_word_index, out_valid, word_index == hit_offset[31:2], "word index mismatch")

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import arlt_pkg::*;

  localparam int SLOTS = RANGE_SLOTS_DEF;
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] base;
    logic [31:0] size;
    logic [31:0] mod_tag;
    logic [7:0]  sec_tag;
    logic [31:0] addr;
  } request_t;

  typedef struct packed {
    logic        hit;
    logic        rejected;
    logic [31:0] mod_tag;
    logic [7:0]  section_id;
    logic [31:0] offset;
    logic [29:0] word;
  } lookup_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic hit;
  logic rejected;
  logic [31:0] hit_module;
  logic [7:0] hit_section;
  logic [31:0] hit_offset;
  logic [29:0] word_index;
  request_t current_req = '0;

  request_t request_backlog[$];
  lookup_result_t awaited_results[$];
  logic [31:0] gen_base[$];
  logic [31:0] gen_size[$];

  int cycle_count = 0;
  int error_count = 0;
  int stim_items = 0;
  int tx_idle_pct = 17;
  int rx_idle_pct = 88;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;
  bit word_taken = 1'b0;

  // predicted contents of the range store
  logic [31:0] tbl_base[SLOTS];
  logic [31:0] tbl_size[SLOTS];
  logic [31:0] tbl_module[SLOTS];
  logic [7:0] tbl_section[SLOTS];
  int unsigned tbl_count = 0;

  always #5 clk = ~clk;

  address_range_lookup_table_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (current_req.kind),
    .range_base (current_req.base),
    .range_size (current_req.size),
    .module_tag (current_req.mod_tag),
    .section_tag(current_req.sec_tag),
    .lookup_addr(current_req.addr),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .rejected   (rejected),
    .hit_module (hit_module),
    .hit_section(hit_section),
    .hit_offset (hit_offset),
    .word_index (word_index)
  );

  function automatic int unsigned entries_not_above(logic [31:0] key);
    int unsigned n = 0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_base[i] <= key) n = i + 1;
    end
    return n;
  endfunction

  function automatic lookup_result_t serve_request(request_t r);
    lookup_result_t res;
    logic [31:0] aligned;
    logic [31:0] off;
    int unsigned pos;
    res = '0;
    case (r.kind)
      REQ_CLEAR: tbl_count = 0;
      REQ_INSERT: begin
        aligned = {r.base[31:2], 2'b00};
        if (aligned == 32'd0 || tbl_count >= SLOTS) begin
          res.rejected = 1'b1;
        end else begin
          // place after every entry at or below the new base
          pos = entries_not_above(aligned);
          for (int i = tbl_count; i > pos; i--) begin
            tbl_base[i] = tbl_base[i - 1];
            tbl_size[i] = tbl_size[i - 1];
            tbl_module[i] = tbl_module[i - 1];
            tbl_section[i] = tbl_section[i - 1];
          end
          tbl_base[pos] = aligned;
          tbl_size[pos] = r.size;
          tbl_module[pos] = r.mod_tag;
          tbl_section[pos] = r.sec_tag;
          tbl_count++;
        end
      end
      REQ_LOOKUP: begin
        pos = entries_not_above(r.addr);
        if (pos > 0) begin
          off = r.addr - tbl_base[pos - 1];
          if (off < tbl_size[pos - 1]) begin
            res.hit = 1'b1;
            res.mod_tag = tbl_module[pos - 1];
            res.section_id = tbl_section[pos - 1];
            res.offset = off;
            res.word = off[31:2];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
  endtask

  task automatic push_request(input logic [1:0] kind, input logic [31:0] base,
                              input logic [31:0] size, input logic [31:0] mod_tag,
                              input logic [7:0] sec, input logic [31:0] addr);
    request_t r;
    r.kind = kind;
    r.base = base;
    r.size = size;
    r.mod_tag = mod_tag;
    r.sec_tag = sec;
    r.addr = addr;
    request_backlog = {request_backlog, r};
    if (kind != REQ_SPARE) stim_items++;
  endtask

  task automatic push_clear();
    push_request(REQ_CLEAR, $urandom(), $urandom(), $urandom(), 8'($urandom_range(0, 255)),
                 $urandom());
    gen_base.delete();
    gen_size.delete();
  endtask

  task automatic add_random_range();
    logic [31:0] b;
    logic [31:0] s;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10 && gen_base.size() != 0)
      b = gen_base[$urandom_range(0, gen_base.size() - 1)] | $urandom_range(0, 3);
    else if (pick < 15)
      b = $urandom_range(0, 3);
    else
      b = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 8) s = 32'd0;
    else if (pick < 70) s = $urandom_range(1, 4096);
    else s = $urandom();
    push_request(REQ_INSERT, b, s, $urandom(), 8'($urandom_range(0, 255)), $urandom());
    if (b[31:2] != 30'd0) begin
      gen_base = {gen_base, {b[31:2], 2'b00}};
      gen_size = {gen_size, s};
    end
  endtask

  task automatic probe_random_addr();
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] s;
    int k;
    if (gen_base.size() == 0 || $urandom_range(0, 7) == 0) begin
      a = $urandom();
    end else begin
      // aim at the edges and interior of a range already sent
      k = $urandom_range(0, gen_base.size() - 1);
      b = gen_base[k];
      s = gen_size[k];
      case ($urandom_range(0, 5))
        0: a = b;
        1: a = b - 1;
        2: a = b + s;
        3: a = b + s - 1;
        default: a = b + ((s == 0) ? 32'd0 : $urandom() % s);
      endcase
    end
    push_request(REQ_LOOKUP, $urandom(), $urandom(), $urandom(), 8'($urandom_range(0, 255)),
                 a);
  endtask

  task automatic run_session(input bit fill);
    int n;
    int pick;
    n = fill ? 90 : $urandom_range(4, 50);
    if (fill || $urandom_range(0, 3) != 0) push_clear();
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (fill) begin
        if (i < 70) add_random_range();
        else probe_random_addr();
      end else if (pick < 50) begin
        add_random_range();
      end else if (pick < 94) begin
        probe_random_addr();
      end else if (pick < 97) begin
        push_request(REQ_SPARE, $urandom(), $urandom(), $urandom(),
                     8'($urandom_range(0, 255)), $urandom());
      end else begin
        push_clear();
      end
    end
  endtask

  task automatic drain();
    while (request_backlog.size() != 0 || in_valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk) begin : take_words
    lookup_result_t expected;
    if (!rst && in_valid && !in_stall) begin
      expected = serve_request(current_req);
      awaited_results = {awaited_results, expected};
      word_taken = 1'b1;
    end
  end

  // hold the word until it is taken, then advance or idle
  always @(negedge clk) begin : drive_words
    if (!rst && (!in_valid || word_taken)) begin
      word_taken = 1'b0;
      if (request_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        current_req <= request_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_stall
    if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : watch_results
    lookup_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected word", {31'd0, hit}, 32'd0);
      end else begin
        want = awaited_results.pop_front();
        if (hit !== want.hit) report_mismatch("hit", 32'(hit), 32'(want.hit));
        if (rejected !== want.rejected)
          report_mismatch("rejected", 32'(rejected), 32'(want.rejected));
        if (hit_module !== want.mod_tag)
          report_mismatch("hit_module", hit_module, want.mod_tag);
        if (hit_section !== want.section_id)
          report_mismatch("hit_section", 32'(hit_section), 32'(want.section_id));
        if (hit_offset !== want.offset) report_mismatch("hit_offset", hit_offset, want.offset);
        if (word_index !== want.word)
          report_mismatch("word_index", 32'(word_index), 32'(want.word));
      end
    end
  end

  initial begin
    // lookup on an empty store, rejected bases
    push_request(REQ_LOOKUP, 32'd0, 32'd0, 32'd0, 8'd0, 32'hFFFF_FFFF);
    push_request(REQ_INSERT, 32'd0, 32'd16, 32'h1111_1111, 8'h11, 32'd0);
    push_request(REQ_INSERT, 32'd3, 32'd16, 32'h2222_2222, 8'h22, 32'd0);
    // top of the address space
    push_request(REQ_INSERT, 32'hFFFF_FFFF, 32'd4, 32'hFFFF_FFFF, 8'hFF, 32'd0);
    push_request(REQ_LOOKUP, 32'd0, 32'd0, 32'd0, 8'd0, 32'hFFFF_FFFF);
    // equal bases: the later range wins, even when it is shorter
    push_request(REQ_INSERT, 32'h0000_1000, 32'h100, 32'hAAAA_0001, 8'h01, 32'd0);
    push_request(REQ_INSERT, 32'h0000_1002, 32'h10, 32'hAAAA_0002, 8'h02, 32'd0);
    push_request(REQ_LOOKUP, 32'd0, 32'd0, 32'd0, 8'd0, 32'h0000_1008);
    push_request(REQ_LOOKUP, 32'd0, 32'd0, 32'd0, 8'd0, 32'h0000_1050);
    push_request(REQ_LOOKUP, 32'd0, 32'd0, 32'd0, 8'd0, 32'h0000_100F);
    push_request(REQ_LOOKUP, 32'd0, 32'd0, 32'd0, 8'd0, 32'h0000_1010);
    push_request(REQ_LOOKUP, 32'd0, 32'd0, 32'd0, 8'd0, 32'h0000_0FFF);
    // zero-size range never hits
    push_request(REQ_INSERT, 32'h0000_2001, 32'd0, 32'hBBBB_0000, 8'h33, 32'd0);
    push_request(REQ_LOOKUP, 32'd0, 32'd0, 32'd0, 8'd0, 32'h0000_2000);
    push_request(REQ_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'h0000_1008);
    push_request(REQ_LOOKUP, 32'd0, 32'd0, 32'd0, 8'd0, 32'h0000_1008);
    push_request(REQ_CLEAR, 32'd0, 32'd0, 32'd0, 8'd0, 32'd0);
    push_request(REQ_LOOKUP, 32'd0, 32'd0, 32'd0, 8'd0, 32'h0000_1008);
    // largest size, largest offset
    push_request(REQ_INSERT, 32'd4, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00, 32'd0);
    push_request(REQ_LOOKUP, 32'd0, 32'd0, 32'd0, 8'd0, 32'hFFFF_FFFF);
    push_request(REQ_LOOKUP, 32'd0, 32'd0, 32'd0, 8'd0, 32'd3);
    push_request(REQ_LOOKUP, 32'd0, 32'd0, 32'd0, 8'd0, 32'd4);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    drain();

    tx_idle_pct = 17;
    rx_idle_pct = 88;
    run_session(1'b1);
    while (stim_items < 220) run_session(1'b0);
    drain();

    tx_idle_pct = 88;
    rx_idle_pct = 17;
    while (stim_items < 420) run_session(1'b0);
    drain();

    // back up the block behind a long receiver hold-off
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_asks++;
    run_session(1'b1);
    while (stim_items < 620) run_session(1'b0);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
